@@ rtl/cnv_pkg.sv @@
// ----------------------------------------------------------------------------
// cnv_pkg: shared types and constants of the 3x3 RGB convolution core
// Register codes, configuration bundle, arithmetic widths and tap access.
// ----------------------------------------------------------------------------
`default_nettype none
package cnv_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_W          = 11;
  localparam int TAP_W          = 16;
  localparam int NUM_TAPS       = 9;
  localparam int PIX_W          = 8;
  localparam int RGB_W          = 3 * PIX_W;
  localparam int COORD_W        = 10;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int PROD_W         = TAP_W + PIX_W + 1;
  localparam int SUM_W          = PROD_W + 4;
  localparam int CLAMP_MAX      = 255;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_TAPS_LOW     = 3'd2,
    REG_TAPS_MID     = 3'd3,
    REG_TAP_LAST     = 3'd4
  } cnv_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]            frame_width;
    logic [DIM_W-1:0]            frame_height;
    logic [NUM_TAPS*TAP_W-1:0]   taps;
  } cnv_cfg_t;

  function automatic logic signed [TAP_W-1:0] tap_at(
    input logic [NUM_TAPS*TAP_W-1:0] taps,
    input int                        t
  );
    tap_at = $signed(taps[t*TAP_W +: TAP_W]);
  endfunction

endpackage
`default_nettype wire

@@ rtl/rgb_convolution_3x3_clamped_core.sv @@
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_clamped_core: streaming 3x3 RGB convolution with clamp
// Configuration registers, filter front end and result expansion back end.
// ----------------------------------------------------------------------------
// A pixel that completes a window passes two more front stages, the queue and
// the output register before its first result shows; a full queue or
// out_stall can hold it. Throughput: one pixel per cycle while in_stall is
// low; results come out one per cycle unless out_stall holds them, and the
// four-entry queue absorbs bursts of up to nine border results per pixel.
// Reset (synchronous, rst_n low) clears counters, pipeline, queue and
// registers; the line buffers are not cleared and need no clearing pass.
`default_nettype none
module rgb_convolution_3x3_clamped_core
  import cnv_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     in_pixel_red,
  input  wire logic [PIX_W-1:0]     in_pixel_green,
  input  wire logic [PIX_W-1:0]     in_pixel_blue,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [COORD_W-1:0]        out_row,
  output logic [COORD_W-1:0]        out_col,
  output logic [PIX_W-1:0]          out_red,
  output logic [PIX_W-1:0]          out_green,
  output logic [PIX_W-1:0]          out_blue,
  output logic                      out_run_last,
  output logic                      out_frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Configuration registers. A geometry write also restarts the raster
  // counters so the next word starts a new frame at row 0, column 0.
  cnv_cfg_t cfg_r, cfg_nxt;
  logic     restart;

  always_comb begin
    cfg_nxt = cfg_r;
    restart = 1'b0;
    if (cfg_we) begin
      case (cnv_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          cfg_nxt.frame_width = cfg_wdata[DIM_W-1:0];
          restart             = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          cfg_nxt.frame_height = cfg_wdata[DIM_W-1:0];
          restart              = 1'b1;
        end
        REG_TAPS_LOW: begin
          cfg_nxt.taps[4*TAP_W-1:0] = cfg_wdata;
        end
        REG_TAPS_MID: begin
          cfg_nxt.taps[8*TAP_W-1:4*TAP_W] = cfg_wdata;
        end
        REG_TAP_LAST: begin
          cfg_nxt.taps[9*TAP_W-1:8*TAP_W] = cfg_wdata[TAP_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // After reset the kernel is the identity: only the center tap is one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= DIM_W'(3);
      cfg_r.frame_height <= DIM_W'(3);
      cfg_r.taps         <= {{(4*TAP_W){1'b0}}, TAP_W'(1), {(4*TAP_W){1'b0}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front pipeline moves as a whole whenever the queue has room, so a
  // word is taken while earlier results are still waiting at the output.
  logic             advance, accept, push, space, push_fend;
  logic [RW-1:0]    push_r_lo, push_r_hi;
  logic [CW-1:0]    push_c_lo, push_c_hi;
  logic [RGB_W-1:0] push_rgb;

  assign advance  = space;
  assign accept   = in_valid && advance;
  assign in_stall = !advance;

  cnv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .restart   (restart),
    .advance   (advance),
    .accept    (accept),
    .pix_in    ({in_pixel_red, in_pixel_green, in_pixel_blue}),
    .push      (push),
    .push_r_lo (push_r_lo),
    .push_r_hi (push_r_hi),
    .push_c_lo (push_c_lo),
    .push_c_hi (push_c_hi),
    .push_rgb  (push_rgb),
    .push_fend (push_fend)
  );

  // The back end walks each queued center over its row and column range,
  // raster order, one result word per cycle unless out_stall holds it.
  cnv_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_r_lo      (push_r_lo),
    .push_r_hi      (push_r_hi),
    .push_c_lo      (push_c_lo),
    .push_c_hi      (push_c_hi),
    .push_rgb       (push_rgb),
    .push_fend      (push_fend),
    .space          (space),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

endmodule
`default_nettype wire

@@ rtl/cnv_ram.sv @@
// ----------------------------------------------------------------------------
// cnv_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module cnv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/cnv_front.sv @@
// ----------------------------------------------------------------------------
// cnv_front: pixel intake, line buffers, window and kernel arithmetic
// Three stages advance together; finished interior results are pushed out.
// ----------------------------------------------------------------------------
`default_nettype none
module cnv_front
  import cnv_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cnv_cfg_t         cfg,
  input  wire logic             restart,
  input  wire logic             advance,
  input  wire logic             accept,
  input  wire logic [RGB_W-1:0] pix_in,
  output logic                  push,
  output logic [RW-1:0]         push_r_lo,
  output logic [RW-1:0]         push_r_hi,
  output logic [CW-1:0]         push_c_lo,
  output logic [CW-1:0]         push_c_hi,
  output logic [RGB_W-1:0]      push_rgb,
  output logic                  push_fend
);

  logic [CW:0] eff_w;
  logic [RW:0] eff_h;

  always_comb begin
    if (cfg.frame_width < DIM_W'(3)) begin
      eff_w = (CW+1)'(3);
    end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(cfg.frame_width);
    end
    if (cfg.frame_height < DIM_W'(3)) begin
      eff_h = (RW+1)'(3);
    end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
      eff_h = (RW+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (RW+1)'(cfg.frame_height);
    end
  end

  // Raster counters.
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          col_end, row_end;

  assign col_end = ({1'b0, col_r} == eff_w - (CW+1)'(1));
  assign row_end = ({1'b0, row_r} == eff_h - (RW+1)'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 0: item registered, line buffers read at its column.
  logic             v0_r;
  logic [CW-1:0]    x0_r;
  logic [RW-1:0]    y0_r;
  logic [RGB_W-1:0] pix0_r;
  logic [2*RGB_W-1:0] lines_rd;   // older row in the upper half

  cnv_ram #(
    .WIDTH (2 * RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .we      (advance && v0_r),
    .waddr   (x0_r),
    .wdata   ({lines_rd[RGB_W-1:0], pix0_r}),
    .re      (accept),
    .raddr   (col_r),
    .rdata_r (lines_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (advance) begin
      v0_r <= accept;
    end
    if (accept) begin
      x0_r   <= col_r;
      y0_r   <= row_r;
      pix0_r <= pix_in;
    end
  end

  // Stage 1: window shifted in, column 0 oldest, three rows per column.
  logic             v1_r;
  logic [CW-1:0]    x1_r;
  logic [RW-1:0]    y1_r;
  logic [RGB_W-1:0] win_r [NUM_TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (advance) begin
      v1_r <= v0_r;
    end
    if (advance && v0_r) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= win_r[i+3];
      end
      win_r[6] <= lines_rd[2*RGB_W-1:RGB_W];
      win_r[7] <= lines_rd[RGB_W-1:0];
      win_r[8] <= pix0_r;
      x1_r     <= x0_r;
      y1_r     <= y0_r;
    end
  end

  // Stage 2: products per channel and tap, output region of this center.
  logic                     top, bottom, left, right, emit;
  logic                     v2_r;
  logic signed [PROD_W-1:0] prod_r [3][NUM_TAPS];
  logic [RW-1:0]            r_lo_r, r_hi_r;
  logic [CW-1:0]            c_lo_r, c_hi_r;
  logic                     fend_r;

  assign top    = (y1_r == RW'(2));
  assign left   = (x1_r == CW'(2));
  assign bottom = ({1'b0, y1_r} == eff_h - (RW+1)'(1));
  assign right  = ({1'b0, x1_r} == eff_w - (CW+1)'(1));
  assign emit   = (y1_r >= RW'(2)) && (x1_r >= CW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (advance) begin
      v2_r <= v1_r && emit;
    end
    if (advance && v1_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int t = 0; t < NUM_TAPS; t++) begin
          prod_r[ch][t] <= tap_at(cfg.taps, t)
                         * $signed({1'b0, win_r[t][(2-ch)*PIX_W +: PIX_W]});
        end
      end
      r_lo_r <= top ? '0 : y1_r - RW'(1);
      r_hi_r <= bottom ? y1_r : y1_r - RW'(1);
      c_lo_r <= left ? '0 : x1_r - CW'(1);
      c_hi_r <= right ? x1_r : x1_r - CW'(1);
      fend_r <= bottom && right;
    end
  end

  // Sum and clamp feed the queue directly.
  logic signed [SUM_W-1:0] sum [3];
  logic [RGB_W-1:0]        rgb;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int t = 0; t < NUM_TAPS; t++) begin
        sum[ch] = sum[ch] + SUM_W'(prod_r[ch][t]);
      end
      if (sum[ch] < 0) begin
        rgb[(2-ch)*PIX_W +: PIX_W] = '0;
      end else if (sum[ch] > SUM_W'(CLAMP_MAX)) begin
        rgb[(2-ch)*PIX_W +: PIX_W] = PIX_W'(CLAMP_MAX);
      end else begin
        rgb[(2-ch)*PIX_W +: PIX_W] = sum[ch][PIX_W-1:0];
      end
    end
  end

  assign push      = advance && v2_r;
  assign push_r_lo = r_lo_r;
  assign push_r_hi = r_hi_r;
  assign push_c_lo = c_lo_r;
  assign push_c_hi = c_hi_r;
  assign push_rgb  = rgb;
  assign push_fend = fend_r;

endmodule
`default_nettype wire

@@ rtl/cnv_back.sv @@
// ----------------------------------------------------------------------------
// cnv_back: result queue and border expansion
// Each queued center result is emitted over its row and column range.
// ----------------------------------------------------------------------------
`default_nettype none
module cnv_back
  import cnv_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [RW-1:0]      push_r_lo,
  input  wire logic [RW-1:0]      push_r_hi,
  input  wire logic [CW-1:0]      push_c_lo,
  input  wire logic [CW-1:0]      push_c_hi,
  input  wire logic [RGB_W-1:0]   push_rgb,
  input  wire logic               push_fend,
  output logic                    space,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [COORD_W-1:0]      out_row,
  output logic [COORD_W-1:0]      out_col,
  output logic [PIX_W-1:0]        out_red,
  output logic [PIX_W-1:0]        out_green,
  output logic [PIX_W-1:0]        out_blue,
  output logic                    out_run_last,
  output logic                    out_frame_last
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  logic [RW-1:0]    q_r_lo [QUEUE_DEPTH];
  logic [RW-1:0]    q_r_hi [QUEUE_DEPTH];
  logic [CW-1:0]    q_c_lo [QUEUE_DEPTH];
  logic [CW-1:0]    q_c_hi [QUEUE_DEPTH];
  logic [RGB_W-1:0] q_rgb  [QUEUE_DEPTH];
  logic             q_fend [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r, cnt_nxt;

  logic             load, pop, last_c, last_all, act_r;
  logic [RW-1:0]    it_r_r, cur_r;
  logic [CW-1:0]    it_c_r, cur_c;
  logic             ov_r;

  assign space = (cnt_r < (QAW+1)'(QUEUE_DEPTH));
  assign load  = (cnt_r != '0) && (!ov_r || !out_stall);

  assign cur_r    = act_r ? it_r_r : q_r_lo[rd_ptr_r];
  assign cur_c    = act_r ? it_c_r : q_c_lo[rd_ptr_r];
  assign last_c   = (cur_c == q_c_hi[rd_ptr_r]);
  assign last_all = last_c && (cur_r == q_r_hi[rd_ptr_r]);
  assign pop      = load && last_all;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      act_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
      end
      if (load) begin
        act_r <= !last_all;
        ov_r  <= 1'b1;
      end else if (!out_stall) begin
        ov_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r_lo[wr_ptr_r] <= push_r_lo;
      q_r_hi[wr_ptr_r] <= push_r_hi;
      q_c_lo[wr_ptr_r] <= push_c_lo;
      q_c_hi[wr_ptr_r] <= push_c_hi;
      q_rgb[wr_ptr_r]  <= push_rgb;
      q_fend[wr_ptr_r] <= push_fend;
    end
    if (load) begin
      if (last_c) begin
        it_c_r <= q_c_lo[rd_ptr_r];
        it_r_r <= cur_r + RW'(1);
      end else begin
        it_c_r <= cur_c + CW'(1);
        it_r_r <= cur_r;
      end
      out_row        <= COORD_W'(cur_r);
      out_col        <= COORD_W'(cur_c);
      out_red        <= q_rgb[rd_ptr_r][3*PIX_W-1:2*PIX_W];
      out_green      <= q_rgb[rd_ptr_r][2*PIX_W-1:PIX_W];
      out_blue       <= q_rgb[rd_ptr_r][PIX_W-1:0];
      out_run_last   <= last_all;
      out_frame_last <= last_all && q_fend[rd_ptr_r];
    end
  end

  assign out_valid = ov_r;

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 RGB convolution core
// Frames of RGB words stream in while a behavioral predictor in the bench
// computes every filtered word, including the border copies. A check process
// compares each result word with the oldest expected word, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import cnv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles from the last accepted word until the pipeline is surely empty.
  localparam int DRAIN_CYCLES = 12;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel_red = '0;
  logic [PIX_W-1:0]     in_pixel_green = '0;
  logic [PIX_W-1:0]     in_pixel_blue = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;
  logic                 out_run_last;
  logic                 out_frame_last;

  always #1 clk = ~clk;

  rgb_convolution_3x3_clamped_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_red   (in_pixel_red),
    .in_pixel_green (in_pixel_green),
    .in_pixel_blue  (in_pixel_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

  // One filtered result word as the core should emit it.
  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic               run_last;
    logic               frame_last;
  } filtered_word_t;

  filtered_word_t filtered_q[$];
  int             error_count = 0;

  // Predictor state: a private copy of the registers, line buffers, window
  // and raster counters. Reset values match the core's register reset.
  logic [DIM_W-1:0] geo_width = 11'd3;
  logic [DIM_W-1:0] geo_height = 11'd3;
  logic [63:0]      taps_low = 64'd0;
  logic [63:0]      taps_mid = 64'd1;
  logic [15:0]      tap_last = 16'd0;
  logic [RGB_W-1:0] row_above[MAX_WIDTH_DEF];
  logic [RGB_W-1:0] row_older[MAX_WIDTH_DEF];
  logic [RGB_W-1:0] window[9];
  int unsigned      cur_row = 0;
  int unsigned      cur_col = 0;

  // Bench control shared between the stimulus and the idling processes.
  bit no_idle = 1'b0;
  int hold_request_id = 0;
  int hold_length = 0;

  initial begin
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      row_above[i] = '0;
      row_older[i] = '0;
    end
    for (int i = 0; i < 9; i++) window[i] = '0;
  end

  function automatic int tap_weight(int t);
    logic [15:0] raw;
    if (t < 4) raw = taps_low[16*t +: 16];
    else if (t < 8) raw = taps_mid[16*(t-4) +: 16];
    else raw = tap_last;
    return int'($signed(raw));
  endfunction

  // Weighted sum of one channel over the window, clamped to a byte.
  function automatic logic [PIX_W-1:0] filter_channel(int shift);
    longint acc;
    acc = 0;
    for (int t = 0; t < 9; t++) begin
      acc += longint'(tap_weight(t)) * longint'((window[(t/3)*3 + t%3] >> shift) & 8'hFF);
    end
    if (acc < 0) acc = 0;
    if (acc > CLAMP_MAX) acc = CLAMP_MAX;
    return acc[PIX_W-1:0];
  endfunction

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_FRAME_WIDTH: begin
        geo_width = v[DIM_W-1:0];
        cur_row = 0;
        cur_col = 0;
      end
      REG_FRAME_HEIGHT: begin
        geo_height = v[DIM_W-1:0];
        cur_row = 0;
        cur_col = 0;
      end
      REG_TAPS_LOW: taps_low = v;
      REG_TAPS_MID: taps_mid = v;
      REG_TAP_LAST: tap_last = v[15:0];
      default: ;
    endcase
  endfunction

  // Advance the raster by one word and queue every result word it completes.
  // An interior centre also stands in for the border words nearest to it.
  function automatic void predict_word(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                       logic [PIX_W-1:0] b);
    int unsigned w, h, y, x, cr, cc, r0, r1, c0, c1;
    logic [RGB_W-1:0] pix, above, older;
    filtered_word_t fw;
    w = clamp_dim(geo_width, MAX_WIDTH_DEF);
    h = clamp_dim(geo_height, MAX_HEIGHT_DEF);
    if (cur_col >= w) cur_col = 0;
    if (cur_row >= h) cur_row = 0;
    y = cur_row;
    x = cur_col;
    pix = {r, g, b};
    above = row_above[x];
    older = row_older[x];
    row_older[x] = above;
    row_above[x] = pix;
    for (int i = 0; i < 6; i++) window[i] = window[i+3];
    window[6] = older;
    window[7] = above;
    window[8] = pix;
    if (y >= 2 && x >= 2) begin
      cr = y - 1;
      cc = x - 1;
      fw.red = filter_channel(16);
      fw.green = filter_channel(8);
      fw.blue = filter_channel(0);
      r0 = (cr == 1) ? 0 : cr;
      r1 = (cr == h - 2) ? h - 1 : cr;
      c0 = (cc == 1) ? 0 : cc;
      c1 = (cc == w - 2) ? w - 1 : cc;
      for (int unsigned yy = r0; yy <= r1; yy++) begin
        for (int unsigned xx = c0; xx <= c1; xx++) begin
          fw.row = yy[COORD_W-1:0];
          fw.col = xx[COORD_W-1:0];
          fw.run_last = (yy == r1) && (xx == c1);
          fw.frame_last = fw.run_last && (y == h - 1) && (x == w - 1);
          filtered_q.push_back(fw);
        end
      end
    end
    cur_col = x + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = y + 1;
      if (cur_row >= h) cur_row = 0;
    end
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, name, exp_v, got_v);
      error_count++;
    end
  endfunction

  // Watch all three ports on every edge. Register writes and accepted words
  // feed the predictor; accepted result words are checked in order.
  always @(posedge clk) begin
    filtered_word_t fw;
    if (rst_n) begin
      if (cfg_we) apply_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) predict_word(in_pixel_red, in_pixel_green, in_pixel_blue);
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: result word with none expected: row %0d col %0d", $realtime,
                   out_row, out_col);
          error_count++;
        end else begin
          fw = filtered_q.pop_front();
          check_field("row", 32'(fw.row), 32'(out_row));
          check_field("col", 32'(fw.col), 32'(out_col));
          check_field("red", 32'(fw.red), 32'(out_red));
          check_field("green", 32'(fw.green), 32'(out_green));
          check_field("blue", 32'(fw.blue), 32'(out_blue));
          check_field("run_last", 32'(fw.run_last), 32'(out_run_last));
          check_field("frame_last", 32'(fw.frame_last), 32'(out_frame_last));
        end
      end
    end
  end

  // Receiver: random stalls, mostly short, with occasional long ones. A hold
  // request from the stimulus forces one long stall counted here in cycles.
  int stall_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    int pick;
    if (hold_request_id != hold_seen) begin
      hold_seen = hold_request_id;
      stall_left = hold_length;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) out_stall <= 1'b0;
      else begin
        out_stall <= 1'b1;
        stall_left = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Offer one word and hold it until it is taken. Valid stays high into the
  // next word when no gap follows.
  task automatic send_word(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    int gap;
    in_valid <= 1'b1;
    in_pixel_red <= r;
    in_pixel_green <= g;
    in_pixel_blue <= b;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, then wait until every expected word has come back and the
  // pipeline has had time to finish words that cause no result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cnv_reg_t idx, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pack_taps(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  task automatic set_kernel(int k[9]);
    write_reg(REG_TAPS_LOW, pack_taps(k[0], k[1], k[2], k[3]));
    write_reg(REG_TAPS_MID, pack_taps(k[4], k[5], k[6], k[7]));
    write_reg(REG_TAP_LAST, {48'hDEAD_BEEF_CAFE, k[8][15:0]});
  endtask

  task automatic set_geometry(int w, int h);
    write_reg(REG_FRAME_WIDTH, CFG_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
  endtask

  // Stream n words. Style 0 gives random bytes, style 1 only 0 and 255.
  task automatic send_words(int n, int style);
    for (int i = 0; i < n; i++) begin
      if (style == 1)
        send_word({8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                  {8{$urandom_range(0, 1) == 1}});
      else
        send_word(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                  PIX_W'($urandom_range(0, 255)));
    end
  endtask

  // Reset geometry and kernel: the identity filter on a 3x3 frame, then a
  // second frame back to back to cover the wrap at frame end.
  task automatic test_reset_identity();
    send_words(9, 1);
    send_words(9, 0);
    wait_drained();
  endtask

  // Saturating kernels at both ends of the tap range and both clamp limits, then an alternating +1/-1 kernel.
  task automatic test_kernel_extremes();
    int k[9];
    set_geometry(4, 4);
    for (int t = 0; t < 9; t++) k[t] = 32767;
    set_kernel(k);
    send_words(16, 1);
    wait_drained();
    for (int t = 0; t < 9; t++) k[t] = -32768;
    set_kernel(k);
    send_words(16, 1);
    wait_drained();
    for (int t = 0; t < 9; t++) k[t] = (t % 2) ? -1 : 1;
    set_kernel(k);
    send_words(16, 0);
    wait_drained();
  endtask

  // Geometry values outside the legal range act as the nearest legal one.
  // The widest and tallest settings are run over the start of a frame.
  task automatic test_geometry_limits();
    int k[9];
    for (int t = 0; t < 9; t++) k[t] = $urandom_range(0, 6) - 3;
    set_kernel(k);
    set_geometry(0, 2);
    send_words(9, 0);
    wait_drained();
    set_geometry(2047, 0);
    send_words(40, 0);
    wait_drained();
    set_geometry(3, 2047);
    send_words(30, 0);
    wait_drained();
  endtask

  // A geometry write in the middle of a frame restarts the raster.
  task automatic test_restart_mid_frame();
    set_geometry(5, 4);
    send_words(13, 0);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, CFG_W'(5));
    send_words(20, 0);
    wait_drained();
  endtask

  // The receiver holds off for a long time while words keep coming, so the
  // result queue fills and the core stalls its input.
  task automatic test_back_pressure();
    set_geometry(6, 6);
    hold_length = 300;
    hold_request_id++;
    no_idle = 1'b1;
    send_words(36, 0);
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Random kernels and small random frames, mostly whole frames, sometimes
  // with a bare run of words and no idling at all.
  task automatic test_random_frames();
    int k[9];
    int sent, w, h, n;
    sent = 0;
    while (sent < 160) begin
      for (int t = 0; t < 9; t++)
        k[t] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
                                           : $urandom_range(0, 8) - 4;
      set_kernel(k);
      w = $urandom_range(3, 8);
      h = $urandom_range(3, 7);
      set_geometry(w, h);
      no_idle = ($urandom_range(0, 3) == 0);
      n = w * h * $urandom_range(1, 2);
      send_words(n, 0);
      sent += n;
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, w * h - 1);
        send_words(n, 0);
        sent += n;
      end
      no_idle = 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_identity();
    test_kernel_extremes();
    test_geometry_limits();
    test_restart_mid_frame();
    test_back_pressure();
    test_random_frames();
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule
